/* hw/rtl/dcs_pkg.sv */
`default_nettype none

package dcs_pkg;

  localparam int unsigned ROW_W      = 5;
  localparam int unsigned COL_W      = 5;
  localparam int unsigned COEF_W     = 7;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned MAT_ADDR_W = ROW_W + COL_W;
  localparam int unsigned MAT_DEPTH  = 1 << MAT_ADDR_W;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  typedef enum logic [1:0] {
    KIND_SYS  = 2'd0,
    KIND_PAR  = 2'd1,
    KIND_VAL  = 2'd2,
    KIND_SALT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SYS,
    ST_PAR,
    ST_VAL
  } state_t;

  typedef struct packed {
    logic              command;
    logic [ROW_W-1:0]  matrix_row;
    logic [COL_W-1:0]  matrix_column;
    logic [COEF_W-1:0] coefficient;
    logic [BYTE_W-1:0] digest_byte;
  } in_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic             last;
    logic             frame_done;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/dcs_parity_cell.sv */
`default_nettype none

// One parity accumulator of the ring; clear wins over shift.
module dcs_parity_cell #(
  parameter int unsigned WIDTH = 7
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dcs_pkg::cell_ctrl_t ctrl,
  input  wire logic [WIDTH-1:0]    d_in,
  output logic      [WIDTH-1:0]    q
);

  logic [WIDTH-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctrl.clear) begin
      acc_r <= '0;
    end else if (ctrl.shift) begin
      acc_r <= d_in;
    end
  end

  assign q = acc_r;

endmodule

`default_nettype wire

/* hw/rtl/dcs_mod_reduce.sv */
`default_nettype none

// Three-stage reduction by a constant modulus: reciprocal estimate,
// back-multiply, then subtract with one correction step.
module dcs_mod_reduce #(
  parameter int unsigned WIDTH   = 16,
  parameter int unsigned MODULUS = 8191
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic [WIDTH-1:0]             in_x,
  output logic                              out_valid,
  output logic [$clog2(MODULUS)-1:0]        out_r
);

  localparam int unsigned RW = $clog2(MODULUS);
  localparam int unsigned MW = $clog2(MODULUS + 1);
  localparam int unsigned CW = WIDTH + MW;
  localparam longint unsigned RECIP_L = (64'd1 << WIDTH) / MODULUS;
  localparam logic [WIDTH-1:0] RECIP = WIDTH'(RECIP_L);
  localparam logic [MW-1:0] MOD_C = MW'(MODULUS);

  logic [2*WIDTH-1:0] est_full;
  logic [CW-1:0]      back_full;
  logic [WIDTH-1:0]   diff;
  logic [CW-1:0]      diff_ext;
  logic [CW-1:0]      diff_sub;
  logic               diff_ge;

  logic             v1_r, v2_r, v3_r;
  logic [WIDTH-1:0] x1_r, x2_r;
  logic [WIDTH-1:0] q1_r;
  logic [WIDTH-1:0] qm_r;
  logic [RW-1:0]    r_r;

  assign est_full  = (2*WIDTH)'(in_x) * (2*WIDTH)'(RECIP);
  assign back_full = CW'(q1_r) * CW'(MOD_C);
  assign diff      = x2_r - qm_r;
  assign diff_ext  = CW'(diff);
  assign diff_sub  = diff_ext - CW'(MOD_C);
  assign diff_ge   = diff_ext >= CW'(MOD_C);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    x1_r <= in_x;
    q1_r <= est_full[2*WIDTH-1:WIDTH];
    x2_r <= x1_r;
    qm_r <= WIDTH'(back_full);
    r_r  <= diff_ge ? RW'(diff_sub) : RW'(diff_ext);
  end

  assign out_valid = v3_r;
  assign out_r     = r_r;

endmodule

`default_nettype wire

/* hw/rtl/digest_to_codeword_sampler.sv */
`default_nettype none

// Digest-to-codeword sampler.
// Input channel (in_valid/in_ready/in_data) carries two kinds of transaction:
// coefficient loads into the 1024-entry matrix and digest bytes. In full
// mode the first ROWS bytes of a frame each give a systematic symbol and are
// folded into PARITY parity symbols, sent after the last row. Then come
// byte pairs (low byte first) giving values mod VALUE_MODULUS, then salt.
// Results leave on out_valid/out_ready/out_data; cfg_wr_en/cfg_wr_data set
// value-only mode, which skips the symbol part.
// Loads, low bytes and salt bytes are done once taken; a high byte waits for
// the 3-stage reduction unit, and a systematic byte for the single read port
// of the coefficient memory feeding the accumulator ring one column per cycle.
// The last row also streams the parity symbols out of the ring. The block
// takes no new transaction until that work is done.
// A symbol or salt result passes through the result register and then the
// output register; a value leaves through the same two after its high byte
// has been reduced, and the parity symbols after the last row's ring update.
// Reset clears the frame position, the mode and the accumulators; matrix
// contents are undefined until loaded. Results pass through a two-entry
// output stage; while the receiver stalls and both entries are full, the
// block takes no new transaction and holds the parity stream in place.
module digest_to_codeword_sampler #(
  parameter int unsigned ROWS          = 32,
  parameter int unsigned PARITY        = 32,
  parameter int unsigned SALT_BYTES    = 32,
  parameter int unsigned SIGMA_MODULUS = 127,
  parameter int unsigned VALUE_MODULUS = 8191
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dcs_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dcs_pkg::out_item_t      out_data,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data
);

  localparam int unsigned CODE_LEN   = ROWS + PARITY;
  localparam int unsigned PAIR_BYTES = 2 * CODE_LEN;
  localparam int unsigned LEN_FULL   = ROWS + PAIR_BYTES + SALT_BYTES;
  localparam int unsigned LEN_VO     = PAIR_BYTES + SALT_BYTES;
  localparam int unsigned POS_W      = $clog2(LEN_FULL);
  localparam int unsigned PW1        = POS_W + 1;
  localparam int unsigned AW         = $clog2(SIGMA_MODULUS);
  localparam int unsigned PROD_W     = AW + dcs_pkg::COEF_W;
  localparam int unsigned VRW        = $clog2(VALUE_MODULUS);
  localparam int unsigned CNT_W      = $clog2(PARITY + 1);

  localparam logic [PW1-1:0]   LEN_FULL_C = PW1'(LEN_FULL);
  localparam logic [PW1-1:0]   LEN_VO_C   = PW1'(LEN_VO);
  localparam logic [PW1-1:0]   ROWS_C     = PW1'(ROWS);
  localparam logic [PW1-1:0]   PAIRS_C    = PW1'(PAIR_BYTES);
  localparam logic [CNT_W-1:0] PARITY_C   = CNT_W'(PARITY);
  localparam logic [CNT_W-1:0] PAR_LAST_C = CNT_W'(PARITY - 1);
  localparam logic [AW:0]      SIGMA_C    = (AW + 1)'(SIGMA_MODULUS);

  // Control state
  dcs_pkg::state_t state_r, state_nxt;
  logic             value_only_r;
  logic [POS_W-1:0] pos_r;
  logic [CNT_W-1:0] col_r;
  logic [CNT_W-1:0] abs_r;
  logic             rd_v_r;
  logic             prod_v_r;
  logic             res_valid_r;
  logic             out_valid_r;

  // Payload state
  logic [dcs_pkg::BYTE_W-1:0] pend_r;
  logic [dcs_pkg::ROW_W-1:0]  row_r;
  logic [AW-1:0]              sym_r;
  logic                       final_r;
  logic [dcs_pkg::IDX_W-1:0]  idx_r;
  logic [dcs_pkg::COEF_W-1:0] coef_q_r;
  logic [PROD_W-1:0]          prod_r;
  dcs_pkg::out_item_t         res_r;
  dcs_pkg::out_item_t         out_r;
  logic [dcs_pkg::COEF_W-1:0] coef_mem [dcs_pkg::MAT_DEPTH];

  // Combinational
  logic                  in_acc;
  logic                  is_byte;
  logic [PW1-1:0]        len_c, sys_c, pos_e, rel_c, salt_c, pos_inc, pos_adv;
  logic                  is_sys, is_val;
  logic [AW-1:0]         sym_lut [256];
  logic [AW-1:0]         sym_c;
  logic                  res_xfer, res_free;
  logic                  res_load;
  dcs_pkg::out_item_t    res_d;
  logic                  issue_v;
  logic                  val_start;
  logic                  ring_upd;
  dcs_pkg::cell_ctrl_t   ring_ctrl;
  logic [AW-1:0]         acc_q [PARITY];
  logic [AW-1:0]         head, feed;
  logic [AW:0]           sum_c;
  logic                  red_v;
  logic [AW-1:0]         red;
  logic                  val_v;
  logic [VRW-1:0]        val_r;
  logic [dcs_pkg::MAT_ADDR_W-1:0] rd_addr, wr_addr;

  // Byte mod SIGMA_MODULUS lookup
  for (genvar gi = 0; gi < 256; gi++) begin : g_sym_lut
    assign sym_lut[gi] = AW'(gi % SIGMA_MODULUS);
  end

  assign in_acc  = in_valid && in_ready;
  assign is_byte = in_data.command == dcs_pkg::CMD_BYTE;
  assign sym_c   = sym_lut[in_data.digest_byte];

  // Frame position decode; a position past the current frame length restarts
  always_comb begin
    len_c   = value_only_r ? LEN_VO_C : LEN_FULL_C;
    sys_c   = value_only_r ? '0 : ROWS_C;
    pos_e   = (PW1'(pos_r) >= len_c) ? '0 : PW1'(pos_r);
    is_sys  = pos_e < sys_c;
    is_val  = pos_e < (sys_c + PAIRS_C);
    rel_c   = pos_e - sys_c;
    salt_c  = pos_e - sys_c - PAIRS_C;
    pos_inc = pos_e + PW1'(1);
    pos_adv = (pos_inc == len_c) ? '0 : pos_inc;
  end

  assign res_xfer = res_valid_r && (!out_valid_r || out_ready);
  assign res_free = !res_valid_r || res_xfer;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dcs_pkg::ST_IDLE: begin
        if (in_acc && is_byte) begin
          if (is_sys) begin
            state_nxt = dcs_pkg::ST_SYS;
          end else if (is_val && rel_c[0]) begin
            state_nxt = dcs_pkg::ST_VAL;
          end
        end
      end
      dcs_pkg::ST_SYS: begin
        if (red_v && abs_r == PAR_LAST_C) begin
          state_nxt = final_r ? dcs_pkg::ST_PAR : dcs_pkg::ST_IDLE;
        end
      end
      dcs_pkg::ST_PAR: begin
        if (res_free && col_r == PAR_LAST_C) begin
          state_nxt = dcs_pkg::ST_IDLE;
        end
      end
      dcs_pkg::ST_VAL: begin
        if (val_v) begin
          state_nxt = dcs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dcs_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready        = 1'b0;
    issue_v         = 1'b0;
    val_start       = 1'b0;
    ring_upd        = 1'b0;
    ring_ctrl.clear = 1'b0;
    ring_ctrl.shift = 1'b0;
    res_load        = 1'b0;
    res_d           = '0;
    case (state_r)
      dcs_pkg::ST_IDLE: begin
        in_ready = res_free;
        if (in_acc && is_byte) begin
          // Start of frame: clear the accumulators
          ring_ctrl.clear = (pos_e == '0);
          if (is_sys) begin
            res_load = 1'b1;
            res_d    = '{kind: dcs_pkg::KIND_SYS, index: dcs_pkg::IDX_W'(pos_e),
                         value: dcs_pkg::VAL_W'(sym_c),
                         last: (pos_e != ROWS_C - PW1'(1)), frame_done: 1'b0};
          end else if (is_val) begin
            val_start = rel_c[0];
          end else begin
            res_load = 1'b1;
            res_d    = '{kind: dcs_pkg::KIND_SALT, index: dcs_pkg::IDX_W'(salt_c),
                         value: dcs_pkg::VAL_W'(in_data.digest_byte), last: 1'b1,
                         frame_done: (pos_inc == len_c)};
          end
        end
      end
      dcs_pkg::ST_SYS: begin
        issue_v         = col_r < PARITY_C;
        ring_upd        = red_v;
        ring_ctrl.shift = red_v;
      end
      dcs_pkg::ST_PAR: begin
        if (res_free) begin
          res_load        = 1'b1;
          ring_ctrl.shift = 1'b1;
          res_d           = '{kind: dcs_pkg::KIND_PAR, index: dcs_pkg::IDX_W'(col_r),
                              value: dcs_pkg::VAL_W'(head),
                              last: (col_r == PAR_LAST_C), frame_done: 1'b0};
        end
      end
      dcs_pkg::ST_VAL: begin
        if (val_v) begin
          res_load = 1'b1;
          res_d    = '{kind: dcs_pkg::KIND_VAL, index: idx_r,
                       value: dcs_pkg::VAL_W'(val_r), last: 1'b1, frame_done: 1'b0};
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dcs_pkg::ST_IDLE;
      value_only_r <= 1'b0;
      pos_r        <= '0;
      col_r        <= '0;
      abs_r        <= '0;
      rd_v_r       <= 1'b0;
      prod_v_r     <= 1'b0;
      res_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_v_r   <= issue_v;
      prod_v_r <= rd_v_r;
      if (cfg_wr_en) begin
        value_only_r <= cfg_wr_data;
      end
      if (in_acc && is_byte) begin
        pos_r <= POS_W'(pos_adv);
      end
      // Column counter: issue columns in ST_SYS, then count parity pushes
      if (in_acc && is_byte && is_sys) begin
        col_r <= '0;
        abs_r <= '0;
      end else if (state_r == dcs_pkg::ST_SYS) begin
        if (state_nxt == dcs_pkg::ST_PAR) begin
          col_r <= '0;
        end else if (issue_v) begin
          col_r <= col_r + CNT_W'(1);
        end
        if (red_v) begin
          abs_r <= abs_r + CNT_W'(1);
        end
      end else if (state_r == dcs_pkg::ST_PAR && res_free) begin
        col_r <= col_r + CNT_W'(1);
      end
      res_valid_r <= (res_valid_r && !res_xfer) || res_load;
      if (res_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc && is_byte) begin
      // Drop the pending low byte at frame start, hold a new one if it is a low byte
      if (is_val && !is_sys && !rel_c[0]) begin
        pend_r <= in_data.digest_byte;
      end else if (pos_e == '0) begin
        pend_r <= '0;
      end
      row_r   <= dcs_pkg::ROW_W'(pos_e);
      sym_r   <= sym_c;
      final_r <= (pos_e == ROWS_C - PW1'(1));
      idx_r   <= dcs_pkg::IDX_W'(rel_c >> 1);
    end
    prod_r <= PROD_W'(sym_r) * PROD_W'(coef_q_r);
    if (res_load) begin
      res_r <= res_d;
    end
    if (res_xfer) begin
      out_r <= res_r;
    end
  end

  // Coefficient memory: write on load transactions, read one column per cycle
  assign wr_addr = {in_data.matrix_row, in_data.matrix_column};
  assign rd_addr = {row_r, dcs_pkg::COL_W'(col_r)};

  always_ff @(posedge clk) begin
    if (in_acc && !is_byte) begin
      coef_mem[wr_addr] <= in_data.coefficient;
    end
    coef_q_r <= coef_mem[rd_addr];
  end

  // Reduce each product mod SIGMA_MODULUS
  dcs_mod_reduce #(
    .WIDTH   (PROD_W),
    .MODULUS (SIGMA_MODULUS)
  ) u_sym_red (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prod_v_r),
    .in_x      (prod_r),
    .out_valid (red_v),
    .out_r     (red)
  );

  // Reduce each assembled 16-bit pair mod VALUE_MODULUS
  dcs_mod_reduce #(
    .WIDTH   (dcs_pkg::VAL_W),
    .MODULUS (VALUE_MODULUS)
  ) u_val_red (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (val_start),
    .in_x      ({in_data.digest_byte, pend_r}),
    .out_valid (val_v),
    .out_r     (val_r)
  );

  // Accumulator ring: the head is updated (or passed unchanged) into the tail
  assign head  = acc_q[0];
  assign sum_c = (AW + 1)'(head) + (AW + 1)'(red);
  assign feed  = ring_upd ? ((sum_c >= SIGMA_C) ? AW'(sum_c - SIGMA_C) : AW'(sum_c)) : head;

  for (genvar gc = 0; gc < PARITY; gc++) begin : g_ring
    if (gc == PARITY - 1) begin : g_tail
      dcs_parity_cell #(.WIDTH(AW)) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ring_ctrl),
        .d_in  (feed),
        .q     (acc_q[gc])
      );
    end else begin : g_body
      dcs_parity_cell #(.WIDTH(AW)) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ring_ctrl),
        .d_in  (acc_q[gc + 1]),
        .q     (acc_q[gc])
      );
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The internal result stage is only loaded when it is free or draining
  a_res_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!res_valid_r || res_xfer))
    else $error("result stage overwritten");

  // Reduced products only arrive while the ring is being updated
  a_red_in_sys : assert property (@(posedge clk) disable iff (!rst_n)
    red_v |-> (state_r == dcs_pkg::ST_SYS))
    else $error("reduced product outside systematic update");

  // Frame position stays inside the longest frame
  a_pos_range : assert property (@(posedge clk) disable iff (!rst_n)
    PW1'(pos_r) < LEN_FULL_C)
    else $error("frame position out of range");

  // Leaving the update phase means every column was issued
  a_sys_done : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dcs_pkg::ST_SYS && state_nxt != dcs_pkg::ST_SYS) |-> (col_r == PARITY_C))
    else $error("update phase ended early");

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

  // Block sizes; keep in step with the instance parameters below.
  localparam int unsigned ROWS          = 32;
  localparam int unsigned PARITY        = 32;
  localparam int unsigned SALT_BYTES    = 32;
  localparam int unsigned SIGMA_MODULUS = 127;
  localparam int unsigned VALUE_MODULUS = 8191;
  localparam int unsigned CODE_LEN      = ROWS + PARITY;

  // Worst item: a last row, whose column work is followed by streaming the
  // parity symbols out. Give it a comfortable margin.
  localparam int unsigned LATENCY        = 2 * PARITY + 16;
  localparam int unsigned RX_HOLD        = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned RANDOM_ITEMS   = 200;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  dcs_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  dcs_pkg::out_item_t out_data;
  logic               cfg_wr_en;
  logic               cfg_wr_data;

  digest_to_codeword_sampler #(
    .ROWS          (ROWS),
    .PARITY        (PARITY),
    .SALT_BYTES    (SALT_BYTES),
    .SIGMA_MODULUS (SIGMA_MODULUS),
    .VALUE_MODULUS (VALUE_MODULUS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Encoder shadow state: matrix, parity sums, frame position, mode.
  // ---------------------------------------------------------------------
  logic [dcs_pkg::COEF_W-1:0] coef_mem [dcs_pkg::MAT_DEPTH];
  logic [dcs_pkg::COEF_W-1:0] parity_sum [PARITY];
  int unsigned                frame_pos;
  logic [dcs_pkg::BYTE_W-1:0] low_byte;
  logic                       value_only;

  dcs_pkg::out_item_t codeword_q [$];
  int unsigned errors;

  // Shared between the stimulus and the receiver process.
  logic calm;          // when high, neither side idles
  int   hold_reqs;     // bump to ask the receiver for a long hold-off

  function automatic void queue_result(dcs_pkg::kind_t k, int unsigned idx,
                                       int unsigned val, logic last, logic done);
    dcs_pkg::out_item_t r;
    r.kind       = k;
    r.index      = dcs_pkg::IDX_W'(idx);
    r.value      = dcs_pkg::VAL_W'(val);
    r.last       = last;
    r.frame_done = done;
    codeword_q.push_back(r);
  endfunction

  // Advance the shadow encoder by one accepted transaction and queue what
  // it should produce.
  task automatic encode_item(dcs_pkg::in_item_t it);
    int unsigned sys_len;
    int unsigned frame_len;
    int unsigned pos;
    int unsigned sym;
    int unsigned acc;
    int unsigned rel;
    logic        final_row;
    if (it.command == dcs_pkg::CMD_LOAD) begin
      coef_mem[{it.matrix_row, it.matrix_column}] = it.coefficient;
      return;
    end
    sys_len   = value_only ? 0 : ROWS;
    frame_len = sys_len + 2 * CODE_LEN + SALT_BYTES;
    // A mode switch can leave the position past the new frame end: restart.
    if (frame_pos >= frame_len) frame_pos = 0;
    pos = frame_pos;
    if (pos == 0) begin
      for (int j = 0; j < PARITY; j++) parity_sum[j] = '0;
      low_byte = '0;
    end
    if (pos < sys_len) begin
      sym       = it.digest_byte % SIGMA_MODULUS;
      final_row = (pos == sys_len - 1);
      queue_result(dcs_pkg::KIND_SYS, pos, sym, !final_row, 1'b0);
      for (int j = 0; j < PARITY; j++) begin
        acc = parity_sum[j] + sym * coef_mem[{pos[4:0], j[4:0]}];
        parity_sum[j] = dcs_pkg::COEF_W'(acc % SIGMA_MODULUS);
      end
      if (final_row) begin
        for (int j = 0; j < PARITY; j++)
          queue_result(dcs_pkg::KIND_PAR, j, parity_sum[j], j == PARITY - 1, 1'b0);
      end
    end else if (pos < sys_len + 2 * CODE_LEN) begin
      rel = pos - sys_len;
      if (rel[0] == 1'b0) begin
        // Low byte of a pair: hold it, nothing comes out.
        low_byte = it.digest_byte;
      end else begin
        queue_result(dcs_pkg::KIND_VAL, rel >> 1,
                     {it.digest_byte, low_byte} % VALUE_MODULUS, 1'b1, 1'b0);
      end
    end else begin
      queue_result(dcs_pkg::KIND_SALT, pos - sys_len - 2 * CODE_LEN, it.digest_byte,
                   1'b1, pos == frame_len - 1);
    end
    frame_pos = pos + 1;
    if (frame_pos >= frame_len) frame_pos = 0;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic dcs_pkg::in_item_t make_byte(logic [dcs_pkg::BYTE_W-1:0] b);
    dcs_pkg::in_item_t it;
    it.command       = dcs_pkg::CMD_BYTE;
    it.matrix_row    = dcs_pkg::ROW_W'($urandom);
    it.matrix_column = dcs_pkg::COL_W'($urandom);
    it.coefficient   = dcs_pkg::COEF_W'($urandom_range(0, SIGMA_MODULUS - 1));
    it.digest_byte   = b;
    return it;
  endfunction

  function automatic dcs_pkg::in_item_t make_load(int unsigned r, int unsigned c,
                                                  int unsigned k);
    dcs_pkg::in_item_t it;
    it.command       = dcs_pkg::CMD_LOAD;
    it.matrix_row    = dcs_pkg::ROW_W'(r);
    it.matrix_column = dcs_pkg::COL_W'(c);
    it.coefficient   = dcs_pkg::COEF_W'(k);
    it.digest_byte   = dcs_pkg::BYTE_W'($urandom);
    return it;
  endfunction

  // Offer one transaction, hold it until accepted, then predict. Called at
  // a clock edge; an idle gap may lower valid first.
  task automatic send_item(dcs_pkg::in_item_t it);
    if (!calm && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    encode_item(it);
  endtask

  // Stop offering and wait until every queued result has come back.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (codeword_q.size() != 0) @(posedge clk);
  endtask

  // Change mode only with the block idle: drain, let any trailing work
  // (low bytes, loads) settle, then write.
  task automatic write_mode(logic m);
    drain();
    repeat (LATENCY) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    value_only   = m;
  endtask

  task automatic send_random_byte;
    case ($urandom_range(0, 7))
      0:       send_item(make_byte(8'h00));
      1:       send_item(make_byte(8'hFF));
      default: send_item(make_byte(dcs_pkg::BYTE_W'($urandom)));
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Fill the whole matrix so no systematic row ever reads an empty entry.
  task automatic test_matrix_load;
    int unsigned k;
    for (int r = 0; r < 32; r++) begin
      for (int c = 0; c < 32; c++) begin
        case ($urandom_range(0, 3))
          0:       k = 0;
          1:       k = SIGMA_MODULUS - 1;
          default: k = $urandom_range(0, SIGMA_MODULUS - 1);
        endcase
        send_item(make_load(r, c, k));
      end
    end
  endtask

  // Field extremes, loads mid-frame, and the mode flipped mid-frame both ways.
  task automatic test_directed;
    write_mode(1'b0);
    send_item(make_byte(8'h00));
    send_item(make_byte(8'hFF));
    send_item(make_byte(8'd126));
    send_item(make_byte(8'd127));
    send_item(make_load(31, 31, SIGMA_MODULUS - 1));
    send_item(make_load(0, 0, 0));
    send_item(make_byte(8'd254));
    send_item(make_byte(8'h80));
    // Six rows in: switch to value-only, so the next byte is a low byte.
    write_mode(1'b1);
    send_item(make_byte(8'hFF));
    send_item(make_byte(8'hFF));
    send_item(make_byte(8'h00));
    send_item(make_byte(8'h00));
    send_item(make_byte(8'hFE));
    send_item(make_byte(8'h1F));
    send_item(make_load(17, 9, 64));
    send_item(make_byte(8'hFF));
    send_item(make_byte(8'h1F));
    // Back to full mode at a position that is still inside the rows.
    write_mode(1'b0);
    send_item(make_byte(8'h01));
    send_item(make_byte(8'hFE));
  endtask

  // Mostly well-formed digest bytes, with matrix reloads thrown in anywhere.
  task automatic test_random_frames;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= 60 && n < 130);
      if ($urandom_range(0, 99) < 10)
        send_item(make_load($urandom_range(0, 31), $urandom_range(0, 31),
                            $urandom_range(0, SIGMA_MODULUS - 1)));
      else
        send_random_byte();
    end
    calm <= 1'b0;
  endtask

  // Receiver holds off while the sender keeps offering: fill the output
  // stage and make the block stall its input.
  task automatic test_backpressure;
    drain();
    calm      <= 1'b1;
    hold_reqs <= hold_reqs + 1;
    for (int n = 0; n < 40; n++) send_random_byte();
    calm <= 1'b0;
    drain();
  endtask

  // Go past the value-only frame length in full mode, then switch: the
  // frame must restart. Run a whole value-only frame and switch back early.
  task automatic test_mode_restart;
    write_mode(1'b0);
    while (frame_pos != 170) send_random_byte();
    write_mode(1'b1);
    for (int n = 0; n < 2 * CODE_LEN + SALT_BYTES + 5; n++) send_random_byte();
    write_mode(1'b0);
    for (int n = 0; n < ROWS + 10; n++) send_random_byte();
  endtask

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk) begin
    dcs_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (codeword_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d index %0d value %0d",
                                  out_data.kind, out_data.index, out_data.value));
      end else begin
        want = codeword_q.pop_front();
        if (out_data.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_data.kind, want.kind));
        if (out_data.index !== want.index)
          report_mismatch($sformatf("index %0d, want %0d", out_data.index, want.index));
        if (out_data.value !== want.value)
          report_mismatch($sformatf("value %0d, want %0d (kind %0d index %0d)",
                                    out_data.value, want.value, want.kind, want.index));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", out_data.last, want.last));
        if (out_data.frame_done !== want.frame_done)
          report_mismatch($sformatf("frame_done %b, want %b",
                                    out_data.frame_done, want.frame_done));
      end
    end
  end

  // Receiver: random stalls, none while calm, and a long hold on request.
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = RX_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 30);
    end
  end

  // Watchdog: drop the run if neither channel moves for too long.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    calm        = 1'b0;
    hold_reqs   = 0;
    errors      = 0;
    frame_pos   = 0;
    low_byte    = '0;
    value_only  = 1'b0;
    for (int j = 0; j < PARITY; j++) parity_sum[j] = '0;
    for (int a = 0; a < dcs_pkg::MAT_DEPTH; a++) coef_mem[a] = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_matrix_load();
    test_directed();
    test_random_frames();
    test_backpressure();
    test_mode_restart();

    // Let the tail settle; anything arriving now is flagged by the checker.
    drain();
    repeat (LATENCY) @(posedge clk);
    if (errors == 0 && codeword_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/dcs_pkg.sv
hw/rtl/dcs_parity_cell.sv
hw/rtl/dcs_mod_reduce.sv
hw/rtl/digest_to_codeword_sampler.sv
tb/tb.sv
